// ===== rtl/hcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types, codes and helpers of the hex command line parser.
// ----------------------------------------------------------------------------
package hcl_pkg;

    // Default limit on data bytes in one command
    localparam int MAX_BYTES_DEF = 32;

    // Result queue depth (two words may be pushed per accepted character)
    localparam int QDEPTH = 4;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 5;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 6;

    // Characters of the command syntax
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End record status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPEED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_HEX    = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_LONG   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_SEP     = 3'd5;

    // One result word
    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [STAT_W-1:0] status;
        logic              fast_mode;
        logic [LEN_W-1:0]  message_length;
        logic              last;
    } t_result;

    // Hex digit decode: {is_hex, nibble}
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_nibble;

    function automatic t_nibble hex_decode(input logic [CHAR_W-1:0] c);
        t_nibble r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // 'A'..'F' and 'a'..'f' share the low bits 1..6
            r.val = c[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic t_result make_end(input logic [STAT_W-1:0] status,
                                         input logic              fast,
                                         input logic [LEN_W-1:0]  len);
        t_result r;
        r.kind           = KIND_END;
        r.data_byte      = 8'd0;
        r.byte_index     = '0;
        r.status         = status;
        r.fast_mode      = fast;
        r.message_length = len;
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic t_result make_data(input logic [7:0]       b,
                                          input logic [IDX_W-1:0] idx,
                                          input logic             fast,
                                          input logic [LEN_W-1:0] len,
                                          input logic             last);
        t_result r;
        r.kind           = KIND_DATA;
        r.data_byte      = b;
        r.byte_index     = idx;
        r.status         = ST_OK;
        r.fast_mode      = fast;
        r.message_length = len;
        r.last           = last;
        return r;
    endfunction

endpackage

// ===== rtl/hcl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_in_if / hcl_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface hcl_in_if;
    logic                           valid;
    logic                           ready;
    logic [hcl_pkg::CHAR_W-1:0]     char_code;
    logic                           end_of_input;

    modport source (output valid, char_code, end_of_input, input ready);
    modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface hcl_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [7:0]                     data_byte;
    logic [hcl_pkg::IDX_W-1:0]      byte_index;
    logic [hcl_pkg::STAT_W-1:0]     status;
    logic                           fast_mode;
    logic [hcl_pkg::LEN_W-1:0]      message_length;
    logic                           last;

    modport source (output valid, kind, data_byte, byte_index, status, fast_mode,
                    message_length, last, input ready);
    modport sink   (input valid, kind, data_byte, byte_index, status, fast_mode,
                    message_length, last, output ready);
endinterface

// ===== rtl/hcl_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_parse
// Parser state and the per-character step: up to two result words per char.
// ----------------------------------------------------------------------------
module hcl_parse #(
    parameter int MAX_BYTES = hcl_pkg::MAX_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [hcl_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_eoi,
    output logic [1:0]                 o_num,
    output hcl_pkg::t_result           o_res0,
    output hcl_pkg::t_result           o_res1
);

    typedef enum logic [2:0] {
        PH_SPEED = 3'd0,
        PH_HIGH  = 3'd1,
        PH_LOW   = 3'd2,
        PH_SEP   = 3'd3,
        PH_DROP  = 3'd4
    } t_phase;

    localparam logic [hcl_pkg::LEN_W-1:0] MaxCount = hcl_pkg::LEN_W'(MAX_BYTES);

    t_phase                     r_phase, n_phase;
    logic [3:0]                 r_high, n_high;
    logic [hcl_pkg::LEN_W-1:0]  r_count, n_count;
    logic                       r_speed, n_speed;

    hcl_pkg::t_nibble           nib;
    logic [hcl_pkg::LEN_W-1:0]  count_inc;
    logic                       is_sign;

    assign nib       = hcl_pkg::hex_decode(i_char);
    assign count_inc = r_count + hcl_pkg::LEN_W'(1);
    assign is_sign   = (i_char == hcl_pkg::CH_PLUS) || (i_char == hcl_pkg::CH_MINUS);

    // Step logic: next state and the result words of this character
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_count = r_count;
        n_speed = r_speed;
        o_num   = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        unique case (r_phase)
            PH_SPEED: begin
                n_count = '0;
                n_high  = 4'd0;
                if (is_sign) begin
                    n_speed = (i_char == hcl_pkg::CH_PLUS);
                    if (i_eoi) begin
                        o_res0  = hcl_pkg::make_end(hcl_pkg::ST_OK, n_speed, '0);
                        o_num   = 2'd1;
                        n_phase = PH_SPEED;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end else begin
                    n_speed = 1'b0;
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_NO_SPEED, 1'b0, '0);
                    o_num   = 2'd1;
                    n_phase = i_eoi ? PH_SPEED : PH_DROP;
                end
            end
            PH_HIGH: begin
                if (i_eoi) begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_INCOMPLETE, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = PH_SPEED;
                end else if (!nib.ok) begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_NOT_HEX, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = PH_DROP;
                end else begin
                    n_high  = nib.val;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (!nib.ok) begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_NOT_HEX, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = i_eoi ? PH_SPEED : PH_DROP;
                end else if (r_count >= MaxCount) begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_TOO_LONG, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = i_eoi ? PH_SPEED : PH_DROP;
                end else begin
                    // data word is the final one unless an end record follows
                    o_res0  = hcl_pkg::make_data({r_high, nib.val},
                                                 r_count[hcl_pkg::IDX_W-1:0],
                                                 r_speed, count_inc, !i_eoi);
                    n_count = count_inc;
                    if (i_eoi) begin
                        o_res1  = hcl_pkg::make_end(hcl_pkg::ST_OK, r_speed, count_inc);
                        o_num   = 2'd2;
                        n_phase = PH_SPEED;
                    end else begin
                        o_num   = 2'd1;
                        n_phase = PH_SEP;
                    end
                end
            end
            PH_SEP: begin
                if (i_char == hcl_pkg::CH_CR) begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_OK, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = i_eoi ? PH_SPEED : PH_DROP;
                end else if (i_char == hcl_pkg::CH_COMMA) begin
                    if (i_eoi) begin
                        o_res0  = hcl_pkg::make_end(hcl_pkg::ST_OK, r_speed, r_count);
                        o_num   = 2'd1;
                        n_phase = PH_SPEED;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end else begin
                    o_res0  = hcl_pkg::make_end(hcl_pkg::ST_NO_SEP, r_speed, r_count);
                    o_num   = 2'd1;
                    n_phase = i_eoi ? PH_SPEED : PH_DROP;
                end
            end
            default: begin
                // Discard until the end of the burst
                if (i_eoi) begin
                    n_phase = PH_SPEED;
                end
            end
        endcase
    end

    // State update on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPEED;
            r_high  <= 4'd0;
            r_count <= '0;
            r_speed <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_count <= n_count;
            r_speed <= n_speed;
        end
    end

endmodule

// ===== rtl/hcl_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_outq
// Small result queue: pushes zero to two words a cycle, pops one when i_ready is high.
// ----------------------------------------------------------------------------
module hcl_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_num,
    input  hcl_pkg::t_result i_res0,
    input  hcl_pkg::t_result i_res1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output hcl_pkg::t_result o_res
);

    localparam int PtrW = $clog2(hcl_pkg::QDEPTH);
    localparam int CntW = $clog2(hcl_pkg::QDEPTH + 1);

    hcl_pkg::t_result      r_mem [hcl_pkg::QDEPTH];
    logic [PtrW-1:0]       r_wr, r_rd;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic                  pop;
    logic [PtrW-1:0]       wr_next;

    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + PtrW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    // Room for the worst case of two words
    assign o_room  = (r_cnt <= CntW'(hcl_pkg::QDEPTH - 2));
    assign n_cnt   = r_cnt + CntW'(i_num) - CntW'(pop);

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_num != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_num == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PtrW'(i_num);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
        end
    end

endmodule

// ===== rtl/hex_command_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_command_line_parser
// Parses "+|-" speed then comma separated hex byte pairs, one char a cycle while i_cmd.ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd takes one character word per cycle (char_code, end_of_input) with a
//   valid/ready handshake. o_res gives result words: data bytes with their
//   index, and one end-of-command record with status, speed and length.
//   The field last marks the final word caused by one character.
// Queueing: the result words of an accepted character are registered into the
//   result queue and offered on o_res from its head, in order.
// Throughput: one character per cycle. A character may cause two words (a
//   byte completed at end of burst), and o_res drains one word per cycle,
//   so ready drops when the four-entry result queue has fewer than two
//   free slots.
// Reset: synchronous, active low; the parser waits for a speed character
//   and the result queue is emptied.
// Stall: while o_res.ready is low, words wait in the queue and i_cmd keeps
//   accepting until the queue is nearly full.
// ----------------------------------------------------------------------------
module hex_command_line_parser #(
    parameter int MAX_BYTES = hcl_pkg::MAX_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcl_in_if.sink    i_cmd,
    hcl_out_if.source o_res
);

    logic             accept;
    logic             room;
    logic [1:0]       num;
    hcl_pkg::t_result res0, res1, head;

    assign i_cmd.ready = room;
    assign accept      = i_cmd.valid && room;

    hcl_parse #(
        .MAX_BYTES (MAX_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_cmd.char_code),
        .i_eoi    (i_cmd.end_of_input),
        .o_num    (num),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    hcl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (accept ? num : 2'd0),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (head)
    );

    // Result word fields
    assign o_res.kind           = head.kind;
    assign o_res.data_byte      = head.data_byte;
    assign o_res.byte_index     = head.byte_index;
    assign o_res.status         = head.status;
    assign o_res.fast_mode      = head.fast_mode;
    assign o_res.message_length = head.message_length;
    assign o_res.last           = head.last;

endmodule

// ===== dv/hcl_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_parse_checker
// Watches the character and result channels of the parser. Each accepted
// character runs through an independent parser model that queues the result
// words it should cause, and each accepted result word is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module hcl_parse_checker #(
    parameter int MAX_BYTES = hcl_pkg::MAX_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // character channel
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_ready,
    input  logic [hcl_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_end_of_input,
    // result channel
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic                       i_kind,
    input  logic [7:0]                 i_data_byte,
    input  logic [hcl_pkg::IDX_W-1:0]  i_byte_index,
    input  logic [hcl_pkg::STAT_W-1:0] i_status,
    input  logic                       i_fast_mode,
    input  logic [hcl_pkg::LEN_W-1:0]  i_message_length,
    input  logic                       i_last,
    // to the testbench top
    output int                         o_pending,
    output int                         o_fail_count
);

    // ASCII bounds of the three hex digit ranges
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    typedef enum logic [2:0] {
        PH_SPEED,
        PH_HIGH,
        PH_LOW,
        PH_SEP,
        PH_DROP
    } t_phase;

    // Model state
    t_phase                    phase;
    logic [3:0]                high_nib;
    logic [hcl_pkg::LEN_W-1:0] byte_cnt;
    logic                      fast;

    // Words still owed by the parser, oldest first
    hcl_pkg::t_result          due_words[$];
    int                        fail_total;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        fail_total++;
        $display("[%0t] result mismatch, %s: got %0d, expected %0d",
                 $time, what, got_v, want_v);
    endtask

    // Nibble value of a hex digit, -1 for any other code
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_DIG_0 && c <= CH_DIG_9) return int'(c - CH_DIG_0);
        if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        return -1;
    endfunction

    function automatic hcl_pkg::t_result end_word(input logic [hcl_pkg::STAT_W-1:0] st);
        hcl_pkg::t_result w;
        w                = '0;
        w.kind           = hcl_pkg::KIND_END;
        w.status         = st;
        w.fast_mode      = fast;
        w.message_length = byte_cnt;
        return w;
    endfunction

    // Advance the model by one character and queue the words it causes
    task automatic parse_char(input logic [7:0] c, input logic eoi);
        hcl_pkg::t_result           words[2];
        int                         n;
        int                         nib;
        int                         i;
        logic                       close;
        logic [hcl_pkg::STAT_W-1:0] close_st;
        n        = 0;
        close    = 1'b0;
        close_st = hcl_pkg::ST_OK;
        nib      = nibble_of(c);
        case (phase)
            PH_SPEED: begin
                byte_cnt = '0;
                high_nib = '0;
                if (c == hcl_pkg::CH_PLUS || c == hcl_pkg::CH_MINUS) begin
                    fast = (c == hcl_pkg::CH_PLUS);
                    if (eoi) close = 1'b1;
                    else phase = PH_HIGH;
                end else begin
                    fast     = 1'b0;
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_NO_SPEED;
                end
            end
            PH_HIGH: begin
                // a first digit at burst end is incomplete whatever it is
                if (eoi) begin
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_INCOMPLETE;
                end else if (nib < 0) begin
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_NOT_HEX;
                end else begin
                    high_nib = nib[3:0];
                    phase    = PH_LOW;
                end
            end
            PH_LOW: begin
                if (nib < 0) begin
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_NOT_HEX;
                end else if (byte_cnt >= MAX_BYTES) begin
                    // full command: the extra pair gives no data word
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_TOO_LONG;
                end else begin
                    words[n]                = '0;
                    words[n].kind           = hcl_pkg::KIND_DATA;
                    words[n].data_byte      = {high_nib, nib[3:0]};
                    words[n].byte_index     = byte_cnt[hcl_pkg::IDX_W-1:0];
                    words[n].status         = hcl_pkg::ST_OK;
                    words[n].fast_mode      = fast;
                    words[n].message_length = byte_cnt + 1'b1;
                    n++;
                    byte_cnt = byte_cnt + 1'b1;
                    if (eoi) close = 1'b1;
                    else phase = PH_SEP;
                end
            end
            PH_SEP: begin
                if (c == hcl_pkg::CH_CR) begin
                    close = 1'b1;
                end else if (c == hcl_pkg::CH_COMMA) begin
                    if (eoi) close = 1'b1;
                    else phase = PH_HIGH;
                end else begin
                    close    = 1'b1;
                    close_st = hcl_pkg::ST_NO_SEP;
                end
            end
            default: begin
                // dropping rest of the burst, silent
                if (eoi) phase = PH_SPEED;
            end
        endcase
        // end of command: resync at once on burst end, else drop the rest
        if (close) begin
            words[n] = end_word(close_st);
            n++;
            phase = eoi ? PH_SPEED : PH_DROP;
        end
        for (i = 0; i < n; i++) begin
            words[i].last = (i == n - 1);
            due_words.push_back(words[i]);
        end
    endtask

    task automatic check_word();
        hcl_pkg::t_result got;
        hcl_pkg::t_result want;
        got = {i_kind, i_data_byte, i_byte_index, i_status, i_fast_mode,
               i_message_length, i_last};
        if (due_words.size() == 0) begin
            report_mismatch("word with nothing expected, kind", got.kind, -1);
        end else begin
            want = due_words.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", got.kind, want.kind);
            if (got.data_byte !== want.data_byte)
                report_mismatch("data_byte", got.data_byte, want.data_byte);
            if (got.byte_index !== want.byte_index)
                report_mismatch("byte_index", got.byte_index, want.byte_index);
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.fast_mode !== want.fast_mode)
                report_mismatch("fast_mode", got.fast_mode, want.fast_mode);
            if (got.message_length !== want.message_length)
                report_mismatch("message_length", got.message_length, want.message_length);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase    = PH_SPEED;
            high_nib = '0;
            byte_cnt = '0;
            fast     = 1'b0;
            due_words.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) parse_char(i_char_code, i_end_of_input);
            if (i_res_valid && i_res_ready) check_word();
        end
        o_pending <= due_words.size();
    end

    initial begin
        fail_total = 0;
    end

endmodule

// ===== dv/tb_hex_command_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_command_line_parser
// Drives character bursts into the parser: a few directed commands for the
// edge cases, then random commands, mostly well formed with random bytes,
// the rest faulty or plain noise. Both channels idle at random; the result
// side also holds off for a long stretch. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_hex_command_line_parser;

    localparam int ITEM_TARGET    = 750;
    localparam int QUIET_TAIL     = 120;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int PAUSE_AT       = 420;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {
        SHAPE_CLEAN,
        SHAPE_HIGH_NOT_HEX,
        SHAPE_LOW_NOT_HEX,
        SHAPE_LONE_DIGIT,
        SHAPE_NO_SEP,
        SHAPE_BAD_SPEED,
        SHAPE_NOISE
    } t_shape;

    typedef enum {
        END_CR,
        END_AT_DIGIT,
        END_AT_COMMA
    } t_ending;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    hcl_in_if  cmd_if ();
    hcl_out_if res_if ();

    int        sent_count;
    int        pending;
    int        fail_count;
    int        idle_pct;
    int        stall_pct;
    int        no_accept_cycles;
    bit        quiet;
    bit        hold_req;
    bit        hold_done;
    bit        pause_done;
    string     hex_digits = "0123456789ABCDEFabcdef";

    hex_command_line_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    hcl_parse_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_if.valid),
        .i_cmd_ready      (cmd_if.ready),
        .i_char_code      (cmd_if.char_code),
        .i_end_of_input   (cmd_if.end_of_input),
        .i_res_valid      (res_if.valid),
        .i_res_ready      (res_if.ready),
        .i_kind           (res_if.kind),
        .i_data_byte      (res_if.data_byte),
        .i_byte_index     (res_if.byte_index),
        .i_status         (res_if.status),
        .i_fast_mode      (res_if.fast_mode),
        .i_message_length (res_if.message_length),
        .i_last           (res_if.last),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] pick_digit();
        return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    endfunction

    // Offer one character word, maybe after an idle burst, and wait for it
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 9);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.char_code    <= c;
        cmd_if.end_of_input <= eoi;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        sent_count++;
    endtask

    task automatic send_text(input string s, input bit eoi_last);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i], eoi_last && i == s.len() - 1);
    endtask

    // Stop offering and wait until every owed word has come out
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One random command burst
    task automatic gen_command();
        logic [7:0] line[$];
        t_shape     shape;
        t_ending    ending;
        logic [7:0] c;
        int         r;
        int         nbytes;
        int         i;
        bit         eoi_last;
        r = $urandom_range(0, 99);
        if (r < 60) shape = SHAPE_CLEAN;
        else if (r < 65) shape = SHAPE_HIGH_NOT_HEX;
        else if (r < 70) shape = SHAPE_LOW_NOT_HEX;
        else if (r < 75) shape = SHAPE_LONE_DIGIT;
        else if (r < 82) shape = SHAPE_NO_SEP;
        else if (r < 90) shape = SHAPE_BAD_SPEED;
        else shape = SHAPE_NOISE;
        // mostly short commands, now and then one near or past the byte limit
        nbytes = ($urandom_range(0, 99) < 4) ?
                 $urandom_range(hcl_pkg::MAX_BYTES_DEF - 2, hcl_pkg::MAX_BYTES_DEF + 1) :
                 $urandom_range(0, 5);
        eoi_last = $urandom_range(0, 1);

        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(0, 255)));
            eoi_last = 1'b1;
        end else if (shape == SHAPE_BAD_SPEED) begin
            do c = 8'($urandom_range(0, 255));
            while (c == hcl_pkg::CH_PLUS || c == hcl_pkg::CH_MINUS);
            line.push_back(c);
        end else begin
            line.push_back($urandom_range(0, 1) ? hcl_pkg::CH_PLUS : hcl_pkg::CH_MINUS);
            for (i = 0; i < nbytes; i++) begin
                if (i > 0) line.push_back(hcl_pkg::CH_COMMA);
                line.push_back(pick_digit());
                line.push_back(pick_digit());
            end
            case (shape)
                SHAPE_HIGH_NOT_HEX, SHAPE_LOW_NOT_HEX, SHAPE_LONE_DIGIT: begin
                    if (nbytes > 0) line.push_back(hcl_pkg::CH_COMMA);
                    if (shape != SHAPE_HIGH_NOT_HEX) line.push_back(pick_digit());
                    if (shape == SHAPE_LONE_DIGIT) begin
                        eoi_last = 1'b1;
                    end else begin
                        // half a digit code moved by one, half anywhere; any hex digit gets bit 7 set
                        if ($urandom_range(0, 1)) c = 8'($urandom_range(0, 255));
                        else if ($urandom_range(0, 1)) c = pick_digit() + 8'd1;
                        else c = pick_digit() - 8'd1;
                        for (i = 0; i < hex_digits.len(); i++)
                            if (c == hex_digits[i]) c[7] = 1'b1;
                        line.push_back(c);
                    end
                end
                SHAPE_NO_SEP: begin
                    if (nbytes == 0) begin
                        line.push_back(pick_digit());
                        line.push_back(pick_digit());
                    end
                    do c = 8'($urandom_range(0, 255));
                    while (c == hcl_pkg::CH_COMMA || c == hcl_pkg::CH_CR);
                    line.push_back(c);
                end
                default: begin
                    ending = t_ending'($urandom_range(0, 2));
                    if (ending == END_CR) begin
                        line.push_back(hcl_pkg::CH_CR);
                    end else begin
                        if (ending == END_AT_COMMA && nbytes > 0)
                            line.push_back(hcl_pkg::CH_COMMA);
                        eoi_last = 1'b1;
                    end
                end
            endcase
        end

        for (i = 0; i < line.size(); i++)
            send_char(line[i], (i == line.size() - 1) ? eoi_last :
                               (shape == SHAPE_NOISE && $urandom_range(0, 3) == 0));
        // burst not closed yet: junk that the parser drops, then burst end
        if (!eoi_last) begin
            repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                res_if.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            no_accept_cycles <= 0;
        end else if (no_accept_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            no_accept_cycles <= no_accept_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.char_code    <= '0;
        cmd_if.end_of_input <= 1'b0;
        no_accept_cycles    = 0;
        sent_count          = 0;
        idle_pct            = 20;
        stall_pct           = 10;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        hold_done           = 1'b0;
        pause_done          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // speed alone at burst end, bad speed at burst end
        send_text("+", 1'b1);
        send_char(8'hFF, 1'b1);
        // bad speed mid burst, rest dropped
        send_char(8'h00, 1'b0);
        send_text("Z", 1'b1);
        // digit range ends, carriage return, dropped high code
        send_text("-09,AF,af\r", 1'b0);
        send_char(8'h80, 1'b1);
        // not hex as first digit; lone digit at burst end
        send_text("+Gx", 1'b1);
        send_text("+5", 1'b1);
        // missing separator; second digit at burst end; comma at burst end
        send_text("+12xq", 1'b1);
        send_text("-34", 1'b1);
        send_text("+7e,", 1'b1);

        // random commands
        while (sent_count < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                idle_pct  = 20 * $urandom_range(0, 2);
                stall_pct = 10 * $urandom_range(0, 2);
            end
            if (sent_count >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent_count >= PAUSE_AT) begin
                drain_results();
                pause_done = 1'b1;
            end
            gen_command();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hcl_pkg.sv
rtl/hcl_if.sv
rtl/hcl_parse.sv
rtl/hcl_outq.sv
rtl/hex_command_line_parser.sv
dv/hcl_parse_checker.sv
dv/tb_hex_command_line_parser.sv
